// ===== sv/gccf_pkg.sv =====
package gccf_pkg;

    localparam int MAX_SIDE_DEF = 64;
    localparam int CFG_W        = 7;
    localparam int OUT_W        = 12;
    localparam logic [CFG_W-1:0] GRID_SIZE_RST = 7'd64;
    localparam logic [OUT_W-1:0] COUNT_MAX     = 12'hFFF;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_TOGGLE = 1'b1
    } t_command;

    // Control word from the sequencer to the label lanes.
    typedef struct packed {
        logic load;     // take a fresh row of colors and seed its labels
        logic replace;  // rewrite every label equal to from_lab as to_lab
        logic rotate;   // shift both rows one column toward the head
        logic push;     // copy the updated current row into the upper row
        logic parity;   // label range of the row being loaded
    } t_lane_ctl;

    // Colors seen at the fixed taps of the lanes.
    typedef struct packed {
        logic head;     // current column, current row
        logic tail;     // previous column, current row
        logic upper;    // current column, upper row
    } t_lane_bits;

endpackage

// ===== sv/gccf_ram.sv =====
module gccf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/gccf_lanes.sv =====
module gccf_lanes #(
    parameter int N  = gccf_pkg::MAX_SIDE_DEF,
    localparam int AW = (N > 1) ? $clog2(N) : 1,
    localparam int LW = AW + 1
) (
    input  logic                  i_clk,
    input  gccf_pkg::t_lane_ctl   i_ctl,
    input  logic [N-1:0]          i_bits,
    input  logic [LW-1:0]         i_from_lab,
    input  logic [LW-1:0]         i_to_lab,
    output gccf_pkg::t_lane_bits  o_bits,
    output logic [LW-1:0]         o_head_lab,
    output logic [LW-1:0]         o_tail_lab,
    output logic [LW-1:0]         o_upper_lab
);

    logic [LW-1:0] r_cur_lab [N];
    logic [LW-1:0] r_prv_lab [N];
    logic [N-1:0]  r_cur_bit;
    logic [N-1:0]  r_prv_bit;

    logic [LW-1:0] w_cur_rep [N];
    logic [LW-1:0] w_prv_rep [N];
    logic [LW-1:0] n_cur_lab [N];
    logic [LW-1:0] n_prv_lab [N];
    logic [N-1:0]  n_cur_bit;
    logic [N-1:0]  n_prv_bit;

    // Every lane compares its own label against the merged-away label, so a
    // union of two regions rewrites all of their labels at once, regardless of their size.
    always_comb begin
        for (int j = 0; j < N; j++) begin
            w_cur_rep[j] = (i_ctl.replace && r_cur_lab[j] == i_from_lab) ? i_to_lab
                                                                          : r_cur_lab[j];
            w_prv_rep[j] = (i_ctl.replace && r_prv_lab[j] == i_from_lab) ? i_to_lab
                                                                          : r_prv_lab[j];
        end
        for (int j = 0; j < N; j++) begin
            if (i_ctl.load) begin
                n_cur_lab[j] = {i_ctl.parity, (LW-1)'(j)};
                n_cur_bit[j] = i_bits[j];
                n_prv_lab[j] = r_prv_lab[j];
                n_prv_bit[j] = r_prv_bit[j];
            end else if (i_ctl.rotate) begin
                n_cur_lab[j] = (j == N-1) ? w_cur_rep[0] : w_cur_rep[(j == N-1) ? 0 : j+1];
                n_cur_bit[j] = (j == N-1) ? r_cur_bit[0] : r_cur_bit[(j == N-1) ? 0 : j+1];
                n_prv_lab[j] = (j == N-1) ? w_prv_rep[0] : w_prv_rep[(j == N-1) ? 0 : j+1];
                n_prv_bit[j] = (j == N-1) ? r_prv_bit[0] : r_prv_bit[(j == N-1) ? 0 : j+1];
            end else begin
                n_cur_lab[j] = w_cur_rep[j];
                n_cur_bit[j] = r_cur_bit[j];
                n_prv_lab[j] = w_prv_rep[j];
                n_prv_bit[j] = r_prv_bit[j];
            end
        end
        if (i_ctl.push) begin
            for (int j = 0; j < N; j++) begin
                n_prv_lab[j] = n_cur_lab[j];
                n_prv_bit[j] = n_cur_bit[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < N; j++) begin
            r_cur_lab[j] <= n_cur_lab[j];
            r_prv_lab[j] <= n_prv_lab[j];
        end
        r_cur_bit <= n_cur_bit;
        r_prv_bit <= n_prv_bit;
    end

    assign o_bits.head  = r_cur_bit[0];
    assign o_bits.tail  = r_cur_bit[N-1];
    assign o_bits.upper = r_prv_bit[0];
    assign o_head_lab   = r_cur_lab[0];
    assign o_tail_lab   = r_cur_lab[N-1];
    assign o_upper_lab  = r_prv_lab[0];

endmodule

// ===== sv/grid_component_count_under_flips_core.sv =====
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_command, i_row, i_col, i_color
// out       output     o_out_valid / i_out_ready  o_black_components, o_white_components
// cfg       input      i_cfg_we                   i_cfg_data (grid size)
//
// A load goes through accept, row read and row write-back.
// A toggle rescans every active row across all MAX_SIDE columns in the label unit,
// which handles one column step per cycle, two steps per cell.
// Reset (i_rst_n low, synchronous) clears control state only; cell storage is undefined.
// The result register holds a count until it is transferred; the core waits for it
// to drain before posting the next count.
module grid_component_count_under_flips_core #(
    parameter int MAX_SIDE = gccf_pkg::MAX_SIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_command,
    input  logic [5:0]                  i_row,
    input  logic [5:0]                  i_col,
    input  logic                        i_color,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [gccf_pkg::OUT_W-1:0]  o_black_components,
    output logic [gccf_pkg::OUT_W-1:0]  o_white_components,
    input  logic                        i_cfg_we,
    input  logic [gccf_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int LW = AW + 1;
    localparam int SW = $clog2(MAX_SIDE + 1) + 1;
    localparam int CW = $clog2(MAX_SIDE * MAX_SIDE + 1) + 1;
    localparam logic [AW-1:0] LAST_COL = AW'(MAX_SIDE - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_RMW_RD, S_RMW_WR, S_ROW_RD, S_ROW_LD, S_COL_L, S_COL_U, S_FIN
    } t_state;

    t_state                     r_state;
    logic [gccf_pkg::CFG_W-1:0] r_grid_size;
    logic                       r_cmd;
    logic                       r_color;
    logic                       r_inside;
    logic [AW-1:0]              r_row;
    logic [AW-1:0]              r_col;
    logic [AW-1:0]              r_r;
    logic [AW-1:0]              r_c;
    logic [CW-1:0]              r_black;
    logic [CW-1:0]              r_white;
    logic                       r_ovalid;
    logic [gccf_pkg::OUT_W-1:0] r_oblack;
    logic [gccf_pkg::OUT_W-1:0] r_owhite;

    logic [SW-1:0]              w_side;
    logic [8:0]                 w_row9;
    logic [8:0]                 w_col9;
    logic                       w_accept;
    logic                       w_active;
    logic                       w_merge_l;
    logic                       w_merge_u;
    logic                       w_last_row;
    logic                       w_we;
    logic [AW-1:0]              w_raddr;
    logic [MAX_SIDE-1:0]        w_rdata;
    logic [MAX_SIDE-1:0]        w_wdata;
    gccf_pkg::t_lane_ctl        w_ctl;
    gccf_pkg::t_lane_bits       w_bits;
    logic [LW-1:0]              w_head_lab;
    logic [LW-1:0]              w_tail_lab;
    logic [LW-1:0]              w_upper_lab;
    logic [LW-1:0]              w_from;
    logic [LW-1:0]              w_to;

    function automatic logic [gccf_pkg::OUT_W-1:0] sat(input logic [CW-1:0] v);
        logic [CW+gccf_pkg::OUT_W-1:0] ext;
        ext = {{gccf_pkg::OUT_W{1'b0}}, v};
        if (ext > (CW+gccf_pkg::OUT_W)'(gccf_pkg::COUNT_MAX)) begin
            return gccf_pkg::COUNT_MAX;
        end
        return ext[gccf_pkg::OUT_W-1:0];
    endfunction

    // Size zero acts as one, sizes above the storage act as the storage side.
    always_comb begin
        if (r_grid_size == '0) begin
            w_side = SW'(1);
        end else if ((SW + 8)'(r_grid_size) > (SW + 8)'(MAX_SIDE)) begin
            w_side = SW'(MAX_SIDE);
        end else begin
            w_side = SW'(r_grid_size);
        end
    end

    assign w_row9     = {3'b000, i_row};
    assign w_col9     = {3'b000, i_col};
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_active   = (SW'(r_c) < w_side);
    assign w_last_row = ((SW'(r_r) + SW'(1)) == w_side);

    // Left union joins two labels of the current row; upward union renames the
    // upper row's label into the current row's range so the ranges stay apart.
    assign w_merge_l = (r_state == S_COL_L) && w_active && (r_c != '0)
                       && (w_bits.head == w_bits.tail) && (w_head_lab != w_tail_lab);
    assign w_merge_u = (r_state == S_COL_U) && w_active && (r_r != '0)
                       && (w_bits.head == w_bits.upper) && (w_head_lab != w_upper_lab);

    assign w_from = (r_state == S_COL_L) ? w_head_lab : w_upper_lab;
    assign w_to   = (r_state == S_COL_L) ? w_tail_lab : w_head_lab;

    always_comb begin
        w_ctl.load    = (r_state == S_ROW_LD);
        w_ctl.replace = w_merge_l || w_merge_u;
        w_ctl.rotate  = (r_state == S_COL_U);
        w_ctl.push    = (r_state == S_COL_U) && (r_c == LAST_COL);
        w_ctl.parity  = r_r[0];
    end

    assign w_raddr = (r_state == S_RMW_RD) ? r_row : r_r;
    assign w_we    = (r_state == S_RMW_WR) && r_inside;

    always_comb begin
        w_wdata = w_rdata;
        if (r_cmd == gccf_pkg::CMD_LOAD) begin
            w_wdata[r_col] = r_color;
        end else begin
            w_wdata[r_col] = ~w_rdata[r_col];
        end
    end

    gccf_ram #(
        .WIDTH (MAX_SIDE),
        .DEPTH (MAX_SIDE)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_row),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    gccf_lanes #(
        .N (MAX_SIDE)
    ) u_lanes (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_bits      (w_rdata),
        .i_from_lab  (w_from),
        .i_to_lab    (w_to),
        .o_bits      (w_bits),
        .o_head_lab  (w_head_lab),
        .o_tail_lab  (w_tail_lab),
        .o_upper_lab (w_upper_lab)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_grid_size <= gccf_pkg::GRID_SIZE_RST;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_grid_size <= i_cfg_data;
            end
            // The final state posts its own result, so it owns the valid flag there.
            if (r_ovalid && i_out_ready && r_state != S_FIN) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd    <= i_command;
                        r_color  <= i_color;
                        r_row    <= w_row9[AW-1:0];
                        r_col    <= w_col9[AW-1:0];
                        r_inside <= (w_row9 < 9'(MAX_SIDE)) && (w_col9 < 9'(MAX_SIDE));
                        r_state  <= S_RMW_RD;
                    end
                end
                S_RMW_RD: begin
                    r_state <= S_RMW_WR;
                end
                S_RMW_WR: begin
                    r_r     <= '0;
                    r_black <= '0;
                    r_white <= '0;
                    r_state <= (r_cmd == gccf_pkg::CMD_LOAD) ? S_IDLE : S_ROW_RD;
                end
                S_ROW_RD: begin
                    r_state <= S_ROW_LD;
                end
                S_ROW_LD: begin
                    r_c     <= '0;
                    r_state <= S_COL_L;
                end
                S_COL_L: begin
                    // A new cell opens a region unless it joins its left neighbor.
                    if (w_active && !w_merge_l) begin
                        if (w_bits.head) begin
                            r_black <= r_black + CW'(1);
                        end else begin
                            r_white <= r_white + CW'(1);
                        end
                    end
                    r_state <= S_COL_U;
                end
                S_COL_U: begin
                    if (w_merge_u) begin
                        if (w_bits.head) begin
                            r_black <= r_black - CW'(1);
                        end else begin
                            r_white <= r_white - CW'(1);
                        end
                    end
                    r_c <= r_c + AW'(1);
                    if (r_c == LAST_COL) begin
                        if (w_last_row) begin
                            r_state <= S_FIN;
                        end else begin
                            r_r     <= r_r + AW'(1);
                            r_state <= S_ROW_RD;
                        end
                    end else begin
                        r_state <= S_COL_L;
                    end
                end
                S_FIN: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_ovalid <= 1'b1;
                        r_oblack <= sat(r_black);
                        r_owhite <= sat(r_white);
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid        = r_ovalid;
    assign o_black_components = r_oblack;
    assign o_white_components = r_owhite;

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_command == gccf_pkg::CMD_LOAD && !o_out_valid) |=> !o_out_valid)
        else $error("load transfer produced a result");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_FIN))
        else $error("result posted outside the final state");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("input accepted while an item is in progress");

    a_single_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_merge_l && w_merge_u))
        else $error("two unions requested in one cycle");

endmodule

// ===== verif/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE       = 64;
    localparam int FILL       = 12;
    localparam int HOLD_LONG  = 3000;
    localparam int CYCLE_CAP  = 3_000_000;

    typedef struct {
        bit                         is_cfg;
        logic [gccf_pkg::CFG_W-1:0] size;
        gccf_pkg::t_command         cmd;
        logic [5:0]                 row;
        logic [5:0]                 col;
        logic                       color;
        bit                         typed;
        logic [gccf_pkg::OUT_W-1:0] black;
        logic [gccf_pkg::OUT_W-1:0] white;
    } t_step;

    typedef struct {
        logic [gccf_pkg::OUT_W-1:0] black;
        logic [gccf_pkg::OUT_W-1:0] white;
    } t_counts;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic                       i_command = 1'b0;
    logic [5:0]                 i_row = '0;
    logic [5:0]                 i_col = '0;
    logic                       i_color = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [gccf_pkg::OUT_W-1:0] o_black_components;
    logic [gccf_pkg::OUT_W-1:0] o_white_components;
    logic                       i_cfg_we = 1'b0;
    logic [gccf_pkg::CFG_W-1:0] i_cfg_data = gccf_pkg::GRID_SIZE_RST;

    logic                       image [SIDE][SIDE];
    logic [gccf_pkg::CFG_W-1:0] size_shadow = gccf_pkg::GRID_SIZE_RST;
    t_counts                    pending_counts[$];
    t_step                      directed[$];
    int                         fails = 0;
    int                         cycles = 0;
    bit                         hold_req = 1'b0;
    bit                         quiet = 1'b0;

    grid_component_count_under_flips_core u_dut (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("grid_component_count_under_flips_core regression: fail");
            $finish;
        end
    end

    function automatic int active_side();
        int n;
        n = size_shadow;
        if (n < 1) n = 1;
        if (n > SIDE) n = SIDE;
        return n;
    endfunction

    // Flood fill over the active square; every unvisited cell starts a new region.
    function automatic t_counts count_regions();
        bit      seen [SIDE*SIDE];
        int      stack [SIDE*SIDE];
        int      sp, n, nb, nw, q, cr, cc, k, d, nr, nc;
        t_counts res;
        n = active_side();
        nb = 0;
        nw = 0;
        for (k = 0; k < SIDE*SIDE; k++) seen[k] = 1'b0;
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                if (!seen[r*SIDE+c]) begin
                    if (image[r][c]) nb++;
                    else nw++;
                    seen[r*SIDE+c] = 1'b1;
                    sp = 0;
                    stack[sp] = r*SIDE+c;
                    sp = sp + 1;
                    while (sp > 0) begin
                        sp = sp - 1;
                        q = stack[sp];
                        cr = q / SIDE;
                        cc = q % SIDE;
                        for (d = 0; d < 4; d++) begin
                            nr = cr + (d == 0) - (d == 1);
                            nc = cc + (d == 2) - (d == 3);
                            if (nr >= 0 && nr < n && nc >= 0 && nc < n &&
                                !seen[nr*SIDE+nc] && image[nr][nc] == image[cr][cc]) begin
                                seen[nr*SIDE+nc] = 1'b1;
                                stack[sp] = nr*SIDE+nc;
                                sp = sp + 1;
                            end
                        end
                    end
                end
            end
        end
        res.black = (nb > gccf_pkg::COUNT_MAX) ? gccf_pkg::COUNT_MAX
                                                : nb[gccf_pkg::OUT_W-1:0];
        res.white = (nw > gccf_pkg::COUNT_MAX) ? gccf_pkg::COUNT_MAX
                                                : nw[gccf_pkg::OUT_W-1:0];
        return res;
    endfunction

    function automatic t_step item(gccf_pkg::t_command cmd, int row, int col, logic color,
                                   bit typed = 0, int black = 0, int white = 0);
        t_step s;
        s.is_cfg = 0;
        s.size   = '0;
        s.cmd    = cmd;
        s.row    = row[5:0];
        s.col    = col[5:0];
        s.color  = color;
        s.typed  = typed;
        s.black  = black[gccf_pkg::OUT_W-1:0];
        s.white  = white[gccf_pkg::OUT_W-1:0];
        return s;
    endfunction

    function automatic t_step size_write(int size);
        t_step s;
        s = item(gccf_pkg::CMD_LOAD, 0, 0, 1'b0);
        s.is_cfg = 1;
        s.size   = size[gccf_pkg::CFG_W-1:0];
        return s;
    endfunction

    // Sends one item and updates the predictor at the edge where it transfers.
    task automatic send(gccf_pkg::t_command cmd, logic [5:0] row, logic [5:0] col,
                        logic color, bit typed, logic [gccf_pkg::OUT_W-1:0] black,
                        logic [gccf_pkg::OUT_W-1:0] white);
        int      gap;
        t_counts exp_counts;
        gap = quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_row      <= row;
        i_col      <= col;
        i_color    <= color;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (cmd == gccf_pkg::CMD_LOAD) begin
            image[row][col] = color;
        end else begin
            image[row][col] = ~image[row][col];
            exp_counts = count_regions();
            if (typed) begin
                exp_counts.black = black;
                exp_counts.white = white;
            end
            pending_counts.push_back(exp_counts);
        end
    endtask

    // The size register may change only once the core has gone idle.
    task automatic write_size(logic [gccf_pkg::CFG_W-1:0] size);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_counts.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        i_cfg_data <= size;
        i_cfg_we   <= 1'b1;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        size_shadow = size;
    endtask

    always @(posedge i_clk) begin
        t_counts want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_counts.size() == 0) begin
                $display("%0t: unexpected result black=%0d white=%0d", $realtime,
                         o_black_components, o_white_components);
                fails++;
            end else begin
                want = pending_counts.pop_front();
                if (o_black_components !== want.black) begin
                    $display("%0t: black_components expected %0d actual %0d", $realtime,
                             want.black, o_black_components);
                    fails++;
                end
                if (o_white_components !== want.white) begin
                    $display("%0t: white_components expected %0d actual %0d", $realtime,
                             want.white, o_white_components);
                    fails++;
                end
            end
        end
    end

    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_LONG) @(posedge i_clk);
            end else begin
                stall = quiet ? 0 : $urandom_range(0, 17);
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    initial begin
        int sizes[10] = '{3, 5, 8, 1, 0, 4, 6, 2, 7, 12};
        int n;
        t_step s;
        for (int r = 0; r < SIDE; r++)
            for (int c = 0; c < SIDE; c++)
                image[r][c] = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // One cell, a cell outside the square, a zero size, then a two by two board.
        directed.push_back(size_write(1));
        directed.push_back(item(gccf_pkg::CMD_LOAD,   0, 0, 1'b0));
        directed.push_back(item(gccf_pkg::CMD_TOGGLE, 0, 0, 1'b1, 1, 1, 0));
        directed.push_back(item(gccf_pkg::CMD_TOGGLE, 0, 0, 1'b0, 1, 0, 1));
        directed.push_back(item(gccf_pkg::CMD_LOAD,   63, 63, 1'b1));
        directed.push_back(item(gccf_pkg::CMD_TOGGLE, 63, 63, 1'b1, 1, 0, 1));
        directed.push_back(size_write(0));
        directed.push_back(item(gccf_pkg::CMD_LOAD,   5, 5, 1'b0));
        directed.push_back(item(gccf_pkg::CMD_TOGGLE, 5, 5, 1'b0, 1, 0, 1));
        directed.push_back(size_write(2));
        directed.push_back(item(gccf_pkg::CMD_LOAD,   0, 1, 1'b1));
        directed.push_back(item(gccf_pkg::CMD_LOAD,   1, 0, 1'b1));
        directed.push_back(item(gccf_pkg::CMD_LOAD,   1, 1, 1'b0));
        directed.push_back(item(gccf_pkg::CMD_TOGGLE, 1, 1, 1'b0, 1, 1, 1));
        directed.push_back(item(gccf_pkg::CMD_TOGGLE, 0, 0, 1'b0, 1, 1, 0));
        directed.push_back(item(gccf_pkg::CMD_TOGGLE, 0, 0, 1'b1));
        directed.push_back(item(gccf_pkg::CMD_TOGGLE, 1, 1, 1'b0, 1, 2, 2));
        directed.push_back(item(gccf_pkg::CMD_TOGGLE, 0, 1, 1'b0));
        directed.push_back(item(gccf_pkg::CMD_TOGGLE, 0, 1, 1'b1));

        foreach (directed[i]) begin
            s = directed[i];
            if (s.is_cfg) write_size(s.size);
            else send(s.cmd, s.row, s.col, s.color, s.typed, s.black, s.white);
        end

        // Fill the largest square used below so every later address is safe to toggle.
        for (int r = 0; r < FILL; r++)
            for (int c = 0; c < FILL; c++)
                send(gccf_pkg::CMD_LOAD, r[5:0], c[5:0], 1'($urandom_range(0, 1)),
                     0, '0, '0);

        // Small boards with random content; a few addresses land outside the square.
        foreach (sizes[p]) begin
            write_size(sizes[p][gccf_pkg::CFG_W-1:0]);
            n = active_side();
            quiet = (p == 2 || p == 7);
            if (p == 0) hold_req = 1'b1;
            repeat (13) begin
                if ($urandom_range(0, 4) == 0)
                    send(gccf_pkg::t_command'($urandom_range(0, 1)),
                         6'($urandom_range(0, FILL-1)), 6'($urandom_range(0, FILL-1)),
                         1'($urandom_range(0, 1)), 0, '0, '0);
                else
                    send(gccf_pkg::t_command'($urandom_range(0, 1)),
                         6'($urandom_range(0, n-1)), 6'($urandom_range(0, n-1)),
                         1'($urandom_range(0, 1)), 0, '0, '0);
            end
        end
        quiet = 1'b0;
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending_counts.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fails == 0) begin
            $display("grid_component_count_under_flips_core regression: pass");
        end else begin
            $display("grid_component_count_under_flips_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/gccf_pkg.sv
sv/gccf_ram.sv
sv/gccf_lanes.sv
sv/grid_component_count_under_flips_core.sv
verif/testbench.sv
